// ===== hw/rtl/nmea_gga_position_parser_macros.svh =====
// assertion macros for the gga position parser
`ifndef NMEA_GGA_POSITION_PARSER_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define NGP_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define NGP_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define NGP_ASSERT_IMP(label, clk, rstn, a, c)
`define NGP_ASSERT_NXT(label, clk, rstn, a, c)
`endif
`endif

// ===== hw/rtl/ngp_pkg.sv =====
// shared types and constants for the gga position parser
package ngp_pkg;
    localparam int LINE_BYTES_DEF  = 128;
    localparam int FIELD_CHARS_DEF = 15;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [16:0] MS_MAX = 17'd131071;
    localparam logic [19:0] IPART_CAP = 20'd999999;
    localparam logic [27:0] LAT_LIMIT = 28'd90000000;
    localparam logic [28:0] LON_LIMIT = 29'd180000000;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // per-coordinate number scanner state
    typedef struct packed {
        logic [1:0]  phase;
        logic        neg;
        logic [19:0] ipart;
        logic [19:0] frac;
        logic [2:0]  fdigits;
        logic [3:0]  nchars;
        logic        present;
    } coord_t;

    // one request from front to back
    typedef struct packed {
        logic        tick;
        logic        finish;
        logic        first_dollar;
        logic        gga;
        logic [7:0]  quality;
        logic        south;
        logic        west;
        coord_t      lat;
        coord_t      lon;
    } req_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] gga_head(input logic [2:0] p);
        logic [7:0] r;
        begin
            unique case (p)
                3'd0: r = 8'h24;
                3'd1: r = 8'h47;
                3'd2: r = 8'h4E;
                3'd3: r = 8'h47;
                3'd4: r = 8'h47;
                3'd5: r = 8'h41;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction
endpackage

// ===== hw/rtl/ngp_front.sv =====
// line scanner: tokenizes bytes and emits one request per item
module ngp_front #(
    parameter int LINE_BYTES  = ngp_pkg::LINE_BYTES_DEF,
    parameter int FIELD_CHARS = ngp_pkg::FIELD_CHARS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          in_tick,
    input  logic [7:0]    in_byte,
    output ngp_pkg::req_t req
);
    import ngp_pkg::*;
    localparam int PW = $clog2(LINE_BYTES);

    logic [PW-1:0] pos_reg, pos_next;
    logic hdr_reg, hdr_next, dollar_reg, dollar_next, cut_reg, cut_next;
    logic [2:0] comma_reg, comma_next;
    logic fstart_reg, fstart_next, south_reg, south_next, west_reg, west_next;
    logic [1:0] qph_reg, qph_next;
    logic qneg_reg, qneg_next;
    logic [7:0] q_reg, q_next;
    coord_t lat_reg, lat_next, lon_reg, lon_next;

    function automatic coord_t feed(input coord_t a, input logic [7:0] c);
        coord_t r;
        logic [23:0] v;
        begin
            r = a;
            r.present = 1'b1;
            v = {4'd0, a.ipart} * 24'd10 + {20'd0, c[3:0]};
            if ({1'b0, a.nchars} < 5'(FIELD_CHARS)) begin
                r.nchars = a.nchars + 4'd1;
                unique case (a.phase)
                    PH_LEAD: begin
                        if (is_blank(c)) r.phase = PH_LEAD;
                        else if (c == 8'h2B || c == 8'h2D) begin
                            r.neg = (c == 8'h2D); r.phase = PH_INT;
                        end else if (is_digit(c)) begin
                            r.ipart = {16'd0, c[3:0]}; r.phase = PH_INT;
                        end else if (c == 8'h2E) r.phase = PH_FRAC;
                        else r.phase = PH_DONE;
                    end
                    PH_INT: begin
                        if (is_digit(c))
                            r.ipart = (v > {4'd0, IPART_CAP}) ? IPART_CAP : v[19:0];
                        else if (c == 8'h2E) r.phase = PH_FRAC;
                        else r.phase = PH_DONE;
                    end
                    PH_FRAC: begin
                        if (is_digit(c)) begin
                            if (a.fdigits < 3'd6) begin
                                r.frac = 20'(a.frac * 20'd10 + {16'd0, c[3:0]});
                                r.fdigits = a.fdigits + 3'd1;
                            end
                        end else r.phase = PH_DONE;
                    end
                    default: r.phase = PH_DONE;
                endcase
            end
            return r;
        end
    endfunction

    logic is_lf, is_cr, full, fin;
    always_comb begin
        logic [7:0] c;
        logic wipe;
        c = in_byte;
        pos_next = pos_reg; hdr_next = hdr_reg; dollar_next = dollar_reg;
        cut_next = cut_reg; comma_next = comma_reg; fstart_next = fstart_reg;
        south_next = south_reg; west_next = west_reg; qph_next = qph_reg;
        qneg_next = qneg_reg; q_next = q_reg; lat_next = lat_reg; lon_next = lon_reg;
        wipe = 1'b0;
        is_cr = c == 8'd13;
        is_lf = c == 8'd10;
        full = {1'b0, pos_reg} >= (PW+1)'(LINE_BYTES - 1);
        fin = in_valid && !in_tick && is_lf && pos_reg != '0;
        if (in_valid && !in_tick && !is_cr) begin
            if (is_lf) wipe = pos_reg != '0;
            else if (full) wipe = 1'b1;
            else begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == '0) begin
                    dollar_next = c == 8'h24; hdr_next = 1'b1;
                end
                if (c == 8'd0) cut_next = 1'b1;
                if (cut_next) begin
                    if ({1'b0, pos_reg} < (PW+1)'(6)) hdr_next = 1'b0;
                end else begin
                    if ({1'b0, pos_reg} < (PW+1)'(6))
                        hdr_next = hdr_next && (c == gga_head(pos_reg[2:0]) ||
                                   (pos_reg == PW'(2) && c == 8'h50));
                    if (comma_reg != 3'd7) begin
                        unique case (comma_reg)
                            3'd2: lat_next = feed(lat_reg, c);
                            3'd3: if (fstart_reg) south_next = c == 8'h53;
                            3'd4: lon_next = feed(lon_reg, c);
                            3'd5: if (fstart_reg) west_next = c == 8'h57;
                            3'd6: begin
                                unique case (qph_reg)
                                    2'd0: begin
                                        if (is_blank(c)) qph_next = 2'd0;
                                        else if (c == 8'h2B || c == 8'h2D) begin
                                            qneg_next = c == 8'h2D; qph_next = 2'd1;
                                        end else if (is_digit(c)) begin
                                            q_next = {4'd0, c[3:0]}; qph_next = 2'd1;
                                        end else qph_next = 2'd2;
                                    end
                                    2'd1: begin
                                        if (is_digit(c))
                                            q_next = 8'(q_reg * 8'd10 + {4'd0, c[3:0]});
                                        else qph_next = 2'd2;
                                    end
                                    default: qph_next = qph_reg;
                                endcase
                            end
                            default: ;
                        endcase
                        fstart_next = c == 8'h2C;
                        if (c == 8'h2C) comma_next = comma_reg + 3'd1;
                    end
                end
            end
        end
        if (wipe) begin
            pos_next = '0; hdr_next = 1'b0; dollar_next = 1'b0; cut_next = 1'b0;
            comma_next = '0; fstart_next = 1'b0; south_next = 1'b0; west_next = 1'b0;
            qph_next = '0; qneg_next = 1'b0; q_next = '0; lat_next = '0; lon_next = '0;
        end
    end

    always_comb begin
        req.tick = in_tick;
        req.finish = fin;
        req.first_dollar = dollar_reg;
        req.gga = hdr_reg && {1'b0, pos_reg} >= (PW+1)'(6);
        req.quality = qneg_reg ? 8'(8'd0 - q_reg) : q_reg;
        req.south = south_reg;
        req.west = west_reg;
        req.lat = lat_reg;
        req.lon = lon_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0; hdr_reg <= 1'b0; dollar_reg <= 1'b0; cut_reg <= 1'b0;
            comma_reg <= '0; fstart_reg <= 1'b0; south_reg <= 1'b0; west_reg <= 1'b0;
            qph_reg <= '0; qneg_reg <= 1'b0; q_reg <= '0; lat_reg <= '0; lon_reg <= '0;
        end else begin
            pos_reg <= pos_next; hdr_reg <= hdr_next; dollar_reg <= dollar_next;
            cut_reg <= cut_next; comma_reg <= comma_next; fstart_reg <= fstart_next;
            south_reg <= south_next; west_reg <= west_next; qph_reg <= qph_next;
            qneg_reg <= qneg_next; q_reg <= q_next; lat_reg <= lat_next; lon_reg <= lon_next;
        end
    end
endmodule

// ===== hw/rtl/ngp_queue.sv =====
// two-entry request queue between scanner and back end
module ngp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  ngp_pkg::req_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output ngp_pkg::req_t rd_data
);
    import ngp_pkg::*;
    `include "nmea_gga_position_parser_macros.svh"
    req_t mem [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    `NGP_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg != 2'd3)
    `NGP_ASSERT_NXT(a_full_hold, aclk, aresetn, cnt_reg == 2'd2 && !rd, cnt_reg == 2'd2)
    `NGP_ASSERT_IMP(a_ptr_eq, aclk, aresetn, cnt_reg == 2'd0, wp_reg == rp_reg)
endmodule

// ===== hw/rtl/ngp_back.sv =====
// back end: conversion pipeline, silence timer and result register
module ngp_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    input  logic          in_valid,
    output logic          in_ready,
    input  ngp_pkg::req_t in_req,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_alive,
    output logic          out_fix,
    output logic signed [27:0] out_lat,
    output logic signed [28:0] out_lon,
    output logic          out_upd
);
    import ngp_pkg::*;
    `include "nmea_gga_position_parser_macros.svh"

    // stage 1: scale fraction, split degrees and minutes
    // stage 2: minutes*1e6+f, degrees*1e6
    // stage 3: divide by 60 via reciprocal, saturate, sign, commit
    typedef struct packed {
        logic        tick, upd, fixset, fixval, dollar;
        logic [13:0] deg_a, deg_o;
        logic [6:0]  min_a, min_o;
        logic [19:0] f_a, f_o;
        logic        neg_a, neg_o;
    } s1_t;
    typedef struct packed {
        logic        tick, upd, fixset, fixval, dollar;
        logic [33:0] dm_a, dm_o;
        logic [26:0] num_a, num_o;
        logic        neg_a, neg_o;
    } s2_t;

    logic v1_reg, v2_reg, v3_reg;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    logic [15:0] tmo_reg;
    logic [16:0] ms_reg, ms_next;
    logic alive_reg, alive_next, fix_reg, fix_next, upd_reg, upd_next;
    logic signed [27:0] lat_reg, lat_next;
    logic signed [28:0] lon_reg, lon_next;
    logic ov_reg;
    logic adv;

    // output register moves when empty or taken; pipeline stalls with it
    assign adv = !ov_reg || out_ready;
    assign in_ready = adv;

    function automatic logic [19:0] scale_frac(input logic [19:0] f, input logic [2:0] n);
        logic [19:0] r;
        begin
            unique case (n)
                3'd0: r = 20'd0;
                3'd1: r = 20'(f * 20'd100000);
                3'd2: r = 20'(f * 20'd10000);
                3'd3: r = 20'(f * 20'd1000);
                3'd4: r = 20'(f * 20'd100);
                3'd5: r = 20'(f * 20'd10);
                default: r = f;
            endcase
            return r;
        end
    endfunction

    // x / 100 as (x / 4) * ceil(2^23 / 25) >> 23, exact for x below 2^20
    function automatic logic [13:0] div100(input logic [19:0] x);
        logic [36:0] p;
        begin
            p = {19'd0, x[19:2]} * 37'd335545;
            return p[36:23];
        end
    endfunction

    always_comb begin
        logic do_upd;
        logic [13:0] qa, qo;
        do_upd = in_req.finish && in_req.gga && in_req.quality != 8'd0 &&
                 in_req.lat.present && in_req.lon.present;
        qa = div100(in_req.lat.ipart);
        qo = div100(in_req.lon.ipart);
        s1_next.tick = in_req.tick;
        s1_next.dollar = in_req.finish && in_req.first_dollar;
        s1_next.fixset = in_req.finish && in_req.gga;
        s1_next.fixval = in_req.quality != 8'd0;
        s1_next.upd = do_upd;
        s1_next.deg_a = qa;
        s1_next.min_a = 7'(in_req.lat.ipart - 20'({6'd0, qa} * 20'd100));
        s1_next.deg_o = qo;
        s1_next.min_o = 7'(in_req.lon.ipart - 20'({6'd0, qo} * 20'd100));
        s1_next.f_a = scale_frac(in_req.lat.frac, in_req.lat.fdigits);
        s1_next.f_o = scale_frac(in_req.lon.frac, in_req.lon.fdigits);
        s1_next.neg_a = in_req.lat.neg != in_req.south;
        s1_next.neg_o = in_req.lon.neg != in_req.west;
    end

    always_comb begin
        s2_next.tick = s1_reg.tick; s2_next.upd = s1_reg.upd;
        s2_next.fixset = s1_reg.fixset; s2_next.fixval = s1_reg.fixval;
        s2_next.dollar = s1_reg.dollar;
        s2_next.dm_a = 34'({20'd0, s1_reg.deg_a} * 34'd1000000);
        s2_next.dm_o = 34'({20'd0, s1_reg.deg_o} * 34'd1000000);
        s2_next.num_a = 27'({20'd0, s1_reg.min_a} * 27'd1000000) + {7'd0, s1_reg.f_a};
        s2_next.num_o = 27'({20'd0, s1_reg.min_o} * 27'd1000000) + {7'd0, s1_reg.f_o};
        s2_next.neg_a = s1_reg.neg_a; s2_next.neg_o = s1_reg.neg_o;
    end

    function automatic logic [34:0] conv(input logic [33:0] dm, input logic [26:0] num,
                                         input logic [28:0] lim);
        logic [50:0] p;
        logic [34:0] m;
        begin
            // num / 60 as (num / 4) * ceil(2^29 / 15) >> 29, exact for num below 2^27
            p = {26'd0, num[26:2]} * 51'd35791395;
            m = {1'b0, dm} + {13'd0, p[50:29]};
            return (m > {6'd0, lim}) ? {6'd0, lim} : m;
        end
    endfunction

    always_comb begin
        logic [34:0] ma, mo;
        ms_next = ms_reg; alive_next = alive_reg; fix_next = fix_reg;
        lat_next = lat_reg; lon_next = lon_reg; upd_next = 1'b0;
        ma = conv(s2_reg.dm_a, s2_reg.num_a, {1'b0, LAT_LIMIT});
        mo = conv(s2_reg.dm_o, s2_reg.num_o, LON_LIMIT);
        if (v2_reg) begin
            if (s2_reg.tick) begin
                if (ms_reg < MS_MAX) ms_next = ms_reg + 17'd1;
            end else begin
                if (s2_reg.dollar) begin
                    alive_next = 1'b1; ms_next = '0;
                end
                if (s2_reg.fixset) fix_next = s2_reg.fixval;
                if (s2_reg.upd) begin
                    lat_next = s2_reg.neg_a ? -$signed(ma[27:0]) : $signed(ma[27:0]);
                    lon_next = s2_reg.neg_o ? -$signed(mo[28:0]) : $signed(mo[28:0]);
                    upd_next = 1'b1;
                end
            end
            if (ms_next > {1'b0, tmo_reg}) begin
                alive_next = 1'b0; fix_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s1_next; s2_reg <= s2_next;
            if (v2_reg) begin
                upd_reg <= upd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; ov_reg <= 1'b0;
            tmo_reg <= TIMEOUT_RESET; ms_reg <= '0; alive_reg <= 1'b0; fix_reg <= 1'b0;
            lat_reg <= '0; lon_reg <= '0;
        end else begin
            if (cfg_we) tmo_reg <= cfg_wdata;
            if (adv) begin
                v1_reg <= in_valid; v2_reg <= v1_reg; ov_reg <= v2_reg;
                ms_reg <= ms_next; alive_reg <= alive_next; fix_reg <= fix_next;
                lat_reg <= lat_next; lon_reg <= lon_next;
            end
        end
    end

    assign v3_reg = ov_reg;
    assign out_valid = v3_reg;
    assign out_alive = alive_reg;
    assign out_fix = fix_reg;
    assign out_lat = lat_reg;
    assign out_lon = lon_reg;
    assign out_upd = upd_reg;

    `NGP_ASSERT_NXT(a_stall_hold, aclk, aresetn, out_valid && !out_ready,
                    out_valid && $stable(lat_reg) && $stable(alive_reg))
    `NGP_ASSERT_IMP(a_upd_fix, aclk, aresetn, out_valid && out_upd, fix_reg || !alive_reg)
    `NGP_ASSERT_NXT(a_timer, aclk, aresetn, adv && v2_reg && ms_next > {1'b0, tmo_reg},
                    !alive_reg && !fix_reg)
endmodule

// ===== hw/rtl/nmea_gga_position_parser.sv =====
// top level of the nmea gga position parser
//  channel | dir | tdata (low bit up)                         | tuser
//  s_axis  | in  | rx_byte[7:0]                               | opcode
//  m_axis  | out | latitude_e6[27:0], longitude_e6[56:28]     | alive, fix, updated
//  cfg     | in  | silence_timeout_ms[15:0] on cfg_we         | -
// one request per cycle sustained while m_axis is not stalled; each result comes out of the
// three-stage degree conversion (minutes*1e6 then a divide by 60)
// synchronous active-low reset clears line, timer and held position
// a stalled m_axis holds the whole back end; a two-entry queue absorbs the front
module nmea_gga_position_parser #(
    parameter int LINE_BYTES  = ngp_pkg::LINE_BYTES_DEF,
    parameter int FIELD_CHARS = ngp_pkg::FIELD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // latitude_e6, longitude_e6, zero fill
    output logic [2:0]  m_axis_tuser    // receiver_alive, position_fix, position_updated
);
    import ngp_pkg::*;
    req_t fr, qr;
    logic acc, q_ready, q_valid, b_ready, alive, fix, upd;
    logic signed [27:0] lat;
    logic signed [28:0] lon;

    assign s_axis_tready = q_ready;
    assign acc = s_axis_tvalid && q_ready;

    ngp_front #(.LINE_BYTES(LINE_BYTES), .FIELD_CHARS(FIELD_CHARS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(acc),
        .in_tick(s_axis_tuser == OP_TICK), .in_byte(s_axis_tdata), .req(fr));

    ngp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_valid(s_axis_tvalid), .wr_ready(q_ready),
        .wr_data(fr), .rd_valid(q_valid), .rd_ready(b_ready), .rd_data(qr));

    ngp_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(q_valid), .in_ready(b_ready), .in_req(qr),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_alive(alive), .out_fix(fix), .out_lat(lat), .out_lon(lon), .out_upd(upd));

    assign m_axis_tdata = {7'd0, lon, lat};
    assign m_axis_tuser = {upd, fix, alive};
endmodule
